/* sv/voice_channel_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// voice_channel_allocator_unit_assert
// Assertion macros for the voice channel allocator.
// ----------------------------------------------------------------------------
`ifndef VOICE_CHANNEL_ALLOCATOR_UNIT_ASSERT_SVH
`define VOICE_CHANNEL_ALLOCATOR_UNIT_ASSERT_SVH

// implication in the same cycle
`define VCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define VCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/vca_pkg.sv */
// ----------------------------------------------------------------------------
// vca_pkg
// Command, action and state codes shared by the voice channel allocator.
// ----------------------------------------------------------------------------
package vca_pkg;

  typedef enum logic [2:0] {
    CMD_PLAY     = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_RESUME   = 3'd3,
    CMD_QUERY    = 3'd4,
    CMD_STOP_ALL = 3'd5,
    CMD_UPDATE   = 3'd6
  } cmd_t;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_START_ONCE = 3'd1;
  localparam logic [2:0] ACT_START_LOOP = 3'd2;
  localparam logic [2:0] ACT_HALT       = 3'd3;
  localparam logic [2:0] ACT_PAUSE      = 3'd4;
  localparam logic [2:0] ACT_RESUME     = 3'd5;
  localparam logic [2:0] ACT_HALT_ALL   = 3'd6;

  localparam logic [1:0] PS_STOPPED = 2'd0;
  localparam logic [1:0] PS_PLAYING = 2'd1;
  localparam logic [1:0] PS_PAUSED  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

  typedef struct packed {
    logic match_found;
    logic match_paused;
    logic same_found;
    logic loop_found;
    logic any_found;
  } scan_flags_t;

endpackage

/* sv/vca_table.sv */
// ----------------------------------------------------------------------------
// vca_table
// Channel table memory with registered read data and per-entry valid bits.
// ----------------------------------------------------------------------------
module vca_table #(
  parameter int CHANNELS   = 8,
  parameter int ENTRY_BITS = 42
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  output logic [ENTRY_BITS-1:0]      rd_data,
  output logic                       rd_valid,
  input  vca_pkg::tbl_ctl_t          ctl,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
  input  logic [ENTRY_BITS-1:0]      wr_data,
  input  logic [CHANNELS-1:0]        clr_mask,
  output logic [CHANNELS-1:0]        valid_q
);

  logic [ENTRY_BITS-1:0] mem_r [CHANNELS];
  logic [ENTRY_BITS-1:0] rd_data_r;
  logic                  rd_valid_r;
  logic [CHANNELS-1:0]   valid_r;
  logic [CHANNELS-1:0]   valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clr_en) begin
      valid_nxt = valid_nxt & ~clr_mask;
    end
    if (ctl.wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;
  assign valid_q  = valid_r;

endmodule

/* sv/vca_scan.sv */
// ----------------------------------------------------------------------------
// vca_scan
// Walks table read data: finds the handle looked up and the oldest handle of
// each eviction class.
// ----------------------------------------------------------------------------
module vca_scan #(
  parameter int CHANNELS      = 8,
  parameter int HANDLE_BITS   = 32,
  parameter int SOUND_ID_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   clear,
  input  logic                                   rd_issue,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  input  logic [HANDLE_BITS+SOUND_ID_BITS+1:0]   rd_data,
  input  logic                                   rd_valid,
  input  logic [HANDLE_BITS-1:0]                 key_handle,
  input  logic [SOUND_ID_BITS-1:0]               key_sound,
  output vca_pkg::scan_flags_t                   flags,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] match_idx,
  output logic [HANDLE_BITS+SOUND_ID_BITS+1:0]   match_data,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] same_idx,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] loop_idx,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] any_idx
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = HANDLE_BITS + SOUND_ID_BITS + 2;

  logic                     take_r;
  logic [AW-1:0]            tag_r;
  logic [HANDLE_BITS-1:0]   e_handle;
  logic [SOUND_ID_BITS-1:0] e_sound;
  logic                     e_loop;
  logic                     live;
  logic                     hit_match;
  logic                     hit_same;
  logic                     hit_loop;
  logic                     hit_any;

  logic                     match_found_r;
  logic                     same_found_r;
  logic                     loop_found_r;
  logic                     any_found_r;
  logic [AW-1:0]            match_idx_r;
  logic [EW-1:0]            match_data_r;
  logic [AW-1:0]            same_idx_r;
  logic [AW-1:0]            loop_idx_r;
  logic [AW-1:0]            any_idx_r;
  logic [HANDLE_BITS-1:0]   same_h_r;
  logic [HANDLE_BITS-1:0]   loop_h_r;
  logic [HANDLE_BITS-1:0]   any_h_r;

  assign e_handle = rd_data[EW-1 -: HANDLE_BITS];
  assign e_sound  = rd_data[2 +: SOUND_ID_BITS];
  assign e_loop   = rd_data[1];
  assign live     = take_r && rd_valid;

  assign hit_match = live && !match_found_r && (key_handle != '0) && (e_handle == key_handle);
  assign hit_same  = live && (e_sound == key_sound) && (!same_found_r || e_handle < same_h_r);
  assign hit_loop  = live && e_loop && (!loop_found_r || e_handle < loop_h_r);
  assign hit_any   = live && (!any_found_r || e_handle < any_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_r        <= 1'b0;
      match_found_r <= 1'b0;
      same_found_r  <= 1'b0;
      loop_found_r  <= 1'b0;
      any_found_r   <= 1'b0;
    end else begin
      take_r <= rd_issue;
      if (clear) begin
        match_found_r <= 1'b0;
        same_found_r  <= 1'b0;
        loop_found_r  <= 1'b0;
        any_found_r   <= 1'b0;
      end else begin
        if (hit_match) match_found_r <= 1'b1;
        if (hit_same)  same_found_r  <= 1'b1;
        if (hit_loop)  loop_found_r  <= 1'b1;
        if (hit_any)   any_found_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      tag_r <= rd_addr;
    end
    if (hit_match) begin
      match_idx_r  <= tag_r;
      match_data_r <= rd_data;
    end
    if (hit_same) begin
      same_idx_r <= tag_r;
      same_h_r   <= e_handle;
    end
    if (hit_loop) begin
      loop_idx_r <= tag_r;
      loop_h_r   <= e_handle;
    end
    if (hit_any) begin
      any_idx_r <= tag_r;
      any_h_r   <= e_handle;
    end
  end

  assign flags.match_found  = match_found_r;
  assign flags.match_paused = match_data_r[0];
  assign flags.same_found   = same_found_r;
  assign flags.loop_found   = loop_found_r;
  assign flags.any_found    = any_found_r;
  assign match_idx          = match_idx_r;
  assign match_data         = match_data_r;
  assign same_idx           = same_idx_r;
  assign loop_idx           = loop_idx_r;
  assign any_idx            = any_idx_r;

endmodule

/* sv/voice_channel_allocator_unit.sv */
// ----------------------------------------------------------------------------
// voice_channel_allocator_unit
// Mixer voice allocator: play, stop, pause, resume, query, stop all, update.
// ----------------------------------------------------------------------------
// Play, stop, pause, resume and query pass through SCAN, WAIT and DONE before the
// result strobe, one table memory read per channel; stop all, update and unused
// codes go straight from IDLE to DONE. busy is high from the cycle after start until the
// result strobe, when start may be raised again. The result is shown for a
// single cycle with out_valid and must be taken there: there is no back-pressure.
module voice_channel_allocator_unit #(
  parameter int CHANNELS      = 8,
  parameter int SOUND_ID_BITS = 8,
  parameter int HANDLE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_sound_id,
  input  logic        in_loop_flag,
  input  logic [31:0] in_handle_in,
  input  logic [7:0]  in_busy_mask,
  output logic        out_valid,
  output logic [31:0] out_handle_out,
  output logic [2:0]  out_channel_out,
  output logic [2:0]  out_mixer_action,
  output logic        out_voice_stolen,
  output logic [1:0]  out_play_state,
  output logic        out_not_found,
  output logic [7:0]  out_freed_mask
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = HANDLE_BITS + SOUND_ID_BITS + 2;

  vca_pkg::state_t          state_r;
  vca_pkg::state_t          state_nxt;
  logic [2:0]               cmd_r;
  logic [SOUND_ID_BITS-1:0] snd_r;
  logic                     loop_r;
  logic [HANDLE_BITS-1:0]   hin_r;
  logic [7:0]               bmask_r;
  logic [AW-1:0]            idx_r;
  logic [HANDLE_BITS-1:0]   last_handle_r;

  logic                     accept;
  logic                     idx_last;
  logic                     rd_issue;
  logic                     done;
  logic                     to_scan;
  logic [SOUND_ID_BITS+7:0] snd_ext;
  logic [HANDLE_BITS+31:0]  hin_ext;
  logic [HANDLE_BITS+31:0]  hout_ext;
  logic [AW+2:0]            ch_ext;

  logic [EW-1:0]            rd_data;
  logic                     rd_valid;
  logic [CHANNELS-1:0]      valid_q;
  vca_pkg::tbl_ctl_t        tbl_ctl;
  logic [AW-1:0]            wr_addr;
  logic [EW-1:0]            wr_data;
  logic [CHANNELS-1:0]      clr_mask;

  vca_pkg::scan_flags_t     flags;
  logic [AW-1:0]            match_idx;
  logic [EW-1:0]            match_data;
  logic [AW-1:0]            same_idx;
  logic [AW-1:0]            loop_idx;
  logic [AW-1:0]            any_idx;

  logic [CHANNELS-1:0]      busy_vec;
  logic [CHANNELS-1:0]      free_cand;
  logic [CHANNELS-1:0]      freed_vec;
  logic [7:0]               freed8;
  logic                     free_found;
  logic [AW-1:0]            free_idx;
  logic [HANDLE_BITS-1:0]   lh_inc;
  logic [HANDLE_BITS-1:0]   lh_new;

  logic [AW-1:0]            ch;
  logic [HANDLE_BITS-1:0]   handle_nxt;
  logic [2:0]               action_nxt;
  logic                     stolen_nxt;
  logic [1:0]               pstate_nxt;
  logic                     nf_nxt;
  logic [7:0]               freed_nxt;
  logic                     lh_upd;

  assign accept   = start && (state_r == vca_pkg::ST_IDLE);
  assign busy     = (state_r != vca_pkg::ST_IDLE);
  assign rd_issue = (state_r == vca_pkg::ST_SCAN);
  assign done     = (state_r == vca_pkg::ST_DONE);
  assign idx_last = (idx_r == AW'(CHANNELS - 1));
  assign to_scan  = (in_cmd == vca_pkg::CMD_PLAY) || (in_cmd == vca_pkg::CMD_STOP) ||
                    (in_cmd == vca_pkg::CMD_PAUSE) || (in_cmd == vca_pkg::CMD_RESUME) ||
                    (in_cmd == vca_pkg::CMD_QUERY);

  assign snd_ext = {{SOUND_ID_BITS{1'b0}}, in_sound_id};
  assign hin_ext = {{HANDLE_BITS{1'b0}}, in_handle_in};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vca_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = to_scan ? vca_pkg::ST_SCAN : vca_pkg::ST_DONE;
        end
      end
      vca_pkg::ST_SCAN: begin
        if (idx_last) begin
          state_nxt = vca_pkg::ST_WAIT;
        end
      end
      vca_pkg::ST_WAIT: state_nxt = vca_pkg::ST_DONE;
      vca_pkg::ST_DONE: state_nxt = vca_pkg::ST_IDLE;
      default:          state_nxt = vca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= vca_pkg::ST_IDLE;
      last_handle_r <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= done;
      if (lh_upd) begin
        last_handle_r <= lh_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      snd_r   <= snd_ext[SOUND_ID_BITS-1:0];
      loop_r  <= in_loop_flag;
      hin_r   <= hin_ext[HANDLE_BITS-1:0];
      bmask_r <= in_busy_mask;
      idx_r   <= '0;
    end else if (rd_issue && !idx_last) begin
      idx_r <= idx_r + AW'(1);
    end
    if (done) begin
      out_handle_out   <= hout_ext[31:0];
      out_channel_out  <= ch_ext[2:0];
      out_mixer_action <= action_nxt;
      out_voice_stolen <= stolen_nxt;
      out_play_state   <= pstate_nxt;
      out_not_found    <= nf_nxt;
      out_freed_mask   <= freed_nxt;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_busy
    if (i < 8) begin : g_in
      assign busy_vec[i] = bmask_r[i];
    end else begin : g_out
      assign busy_vec[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_freed
    if (i < CHANNELS) begin : g_in
      assign freed8[i] = freed_vec[i];
    end else begin : g_out
      assign freed8[i] = 1'b0;
    end
  end

  assign free_cand = ~valid_q | ~busy_vec;
  assign freed_vec = valid_q & ~busy_vec;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (free_cand[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign lh_inc = last_handle_r + HANDLE_BITS'(1);
  assign lh_new = (lh_inc == '0) ? HANDLE_BITS'(1) : lh_inc;

  always_comb begin
    ch          = '0;
    handle_nxt  = '0;
    action_nxt  = vca_pkg::ACT_NONE;
    stolen_nxt  = 1'b0;
    pstate_nxt  = vca_pkg::PS_STOPPED;
    nf_nxt      = 1'b0;
    freed_nxt   = '0;
    lh_upd      = 1'b0;
    tbl_ctl     = '0;
    wr_addr     = '0;
    wr_data     = '0;
    clr_mask    = '0;
    if (done) begin
      unique case (cmd_r)
        vca_pkg::CMD_PLAY: begin
          priority if (free_found) begin
            ch = free_idx;
          end else if (flags.same_found) begin
            ch = same_idx;
          end else if (flags.loop_found) begin
            ch = loop_idx;
          end else begin
            ch = any_idx;
          end
          stolen_nxt    = !free_found;
          handle_nxt    = lh_new;
          lh_upd        = 1'b1;
          action_nxt    = loop_r ? vca_pkg::ACT_START_LOOP : vca_pkg::ACT_START_ONCE;
          tbl_ctl.wr_en = 1'b1;
          wr_addr       = ch;
          wr_data       = {lh_new, snd_r, loop_r, 1'b0};
        end
        vca_pkg::CMD_STOP, vca_pkg::CMD_PAUSE, vca_pkg::CMD_RESUME: begin
          if (!flags.match_found) begin
            nf_nxt = 1'b1;
          end else begin
            ch      = match_idx;
            wr_addr = match_idx;
            if (cmd_r == vca_pkg::CMD_STOP) begin
              action_nxt     = vca_pkg::ACT_HALT;
              tbl_ctl.clr_en = 1'b1;
              clr_mask       = CHANNELS'(1) << match_idx;
            end else if (cmd_r == vca_pkg::CMD_PAUSE) begin
              if (!flags.match_paused) begin
                action_nxt    = vca_pkg::ACT_PAUSE;
                tbl_ctl.wr_en = 1'b1;
                wr_data       = {match_data[EW-1:1], 1'b1};
              end
            end else begin
              if (flags.match_paused) begin
                action_nxt    = vca_pkg::ACT_RESUME;
                tbl_ctl.wr_en = 1'b1;
                wr_data       = {match_data[EW-1:1], 1'b0};
              end
            end
          end
        end
        vca_pkg::CMD_QUERY: begin
          if (flags.match_found) begin
            pstate_nxt = flags.match_paused ? vca_pkg::PS_PAUSED : vca_pkg::PS_PLAYING;
          end
        end
        vca_pkg::CMD_STOP_ALL: begin
          action_nxt     = vca_pkg::ACT_HALT_ALL;
          tbl_ctl.clr_en = 1'b1;
          clr_mask       = '1;
        end
        vca_pkg::CMD_UPDATE: begin
          freed_nxt      = freed8;
          tbl_ctl.clr_en = 1'b1;
          clr_mask       = freed_vec;
        end
        default: begin
        end
      endcase
    end
  end

  assign hout_ext = {32'b0, handle_nxt};
  assign ch_ext   = {3'b0, ch};

  vca_table #(
    .CHANNELS   (CHANNELS),
    .ENTRY_BITS (EW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_issue),
    .rd_addr  (idx_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .ctl      (tbl_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_mask (clr_mask),
    .valid_q  (valid_q)
  );

  vca_scan #(
    .CHANNELS      (CHANNELS),
    .HANDLE_BITS   (HANDLE_BITS),
    .SOUND_ID_BITS (SOUND_ID_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (accept),
    .rd_issue   (rd_issue),
    .rd_addr    (idx_r),
    .rd_data    (rd_data),
    .rd_valid   (rd_valid),
    .key_handle (hin_r),
    .key_sound  (snd_r),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_data (match_data),
    .same_idx   (same_idx),
    .loop_idx   (loop_idx),
    .any_idx    (any_idx)
  );

`include "voice_channel_allocator_unit_assert.svh"

  `VCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "busy not raised after start")
  `VCA_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `VCA_ASSERT_NOW(a_steal_starts, clk, rst_n, out_valid && out_voice_stolen, (out_mixer_action == vca_pkg::ACT_START_ONCE) || (out_mixer_action == vca_pkg::ACT_START_LOOP), "steal without start")
  `VCA_ASSERT_NOW(a_nf_no_action, clk, rst_n, out_valid && out_not_found, out_mixer_action == vca_pkg::ACT_NONE, "action on unknown handle")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voice channel allocator. A short table of
// directed commands fills, steals, pauses, frees and clears the channel table,
// then random play-heavy traffic with live and stale handles follows. Every
// reply is checked against a behavioural copy of the table kept here.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_CH      = 8;
  localparam int          RANDOM_REQS = 1650;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;

  typedef enum {PICK_SAME, PICK_LOOP, PICK_ANY} steal_pick_t;

  typedef struct {
    logic [31:0] handle;
    logic [2:0]  channel;
    logic [2:0]  action;
    logic        stolen;
    logic [1:0]  pstate;
    logic        not_found;
    logic [7:0]  freed;
  } voice_reply_t;

  typedef struct {
    logic [2:0]   cmd;
    logic [7:0]   sound;
    logic         looping;
    logic [31:0]  handle;
    logic [7:0]   busy_mask;
    bit           typed;
    voice_reply_t want;
  } voice_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = vca_pkg::CMD_PLAY;
  logic [7:0]  in_sound_id = 8'h00;
  logic        in_loop_flag = 1'b0;
  logic [31:0] in_handle_in = 32'h0;
  logic [7:0]  in_busy_mask = 8'h00;
  logic        out_valid;
  logic [31:0] out_handle_out;
  logic [2:0]  out_channel_out;
  logic [2:0]  out_mixer_action;
  logic        out_voice_stolen;
  logic [1:0]  out_play_state;
  logic        out_not_found;
  logic [7:0]  out_freed_mask;

  logic [31:0] slot_handle [NUM_CH];
  logic [7:0]  slot_sound [NUM_CH];
  bit          slot_looping [NUM_CH];
  bit          slot_paused [NUM_CH];
  logic [31:0] last_issued;

  voice_reply_t predicted_replies [$];
  voice_req_t   plan [$];
  voice_reply_t got;
  voice_reply_t want_now;
  int           err_count = 0;
  int           reply_count = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;

  voice_channel_allocator_unit #(
    .CHANNELS     (NUM_CH),
    .SOUND_ID_BITS(8),
    .HANDLE_BITS  (32)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_sound_id     (in_sound_id),
    .in_loop_flag    (in_loop_flag),
    .in_handle_in    (in_handle_in),
    .in_busy_mask    (in_busy_mask),
    .out_valid       (out_valid),
    .out_handle_out  (out_handle_out),
    .out_channel_out (out_channel_out),
    .out_mixer_action(out_mixer_action),
    .out_voice_stolen(out_voice_stolen),
    .out_play_state  (out_play_state),
    .out_not_found   (out_not_found),
    .out_freed_mask  (out_freed_mask)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic voice_reply_t res(logic [31:0] h, logic [2:0] ch, logic [2:0] act,
                                       logic st, logic [1:0] ps, logic nf, logic [7:0] fm);
    voice_reply_t r;
    r.handle    = h;
    r.channel   = ch;
    r.action    = act;
    r.stolen    = st;
    r.pstate    = ps;
    r.not_found = nf;
    r.freed     = fm;
    return r;
  endfunction

  function automatic voice_req_t row(logic [2:0] c, logic [7:0] s, logic l, logic [31:0] h,
                                     logic [7:0] b);
    voice_req_t q;
    q.cmd       = c;
    q.sound     = s;
    q.looping   = l;
    q.handle    = h;
    q.busy_mask = b;
    q.typed     = 1'b0;
    q.want      = res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0, vca_pkg::PS_STOPPED,
                      1'b0, 8'h00);
    return q;
  endfunction

  function automatic voice_req_t row_chk(logic [2:0] c, logic [7:0] s, logic l,
                                         logic [31:0] h, logic [7:0] b, voice_reply_t w);
    voice_req_t q;
    q       = row(c, s, l, h, b);
    q.typed = 1'b1;
    q.want  = w;
    return q;
  endfunction

  function automatic void clear_slot(int i);
    slot_handle[i]  = 32'h0;
    slot_sound[i]   = 8'h00;
    slot_looping[i] = 1'b0;
    slot_paused[i]  = 1'b0;
  endfunction

  function automatic int find_slot(logic [31:0] h);
    int hit;
    hit = -1;
    if (h != 32'h0) begin
      for (int i = NUM_CH - 1; i >= 0; i--) begin
        if (slot_handle[i] == h) hit = i;
      end
    end
    return hit;
  endfunction

  function automatic int oldest_slot(steal_pick_t pick, logic [7:0] snd);
    int best;
    best = -1;
    for (int i = 0; i < NUM_CH; i++) begin
      if (slot_handle[i] != 32'h0 &&
          !(pick == PICK_SAME && slot_sound[i] != snd) &&
          !(pick == PICK_LOOP && !slot_looping[i]) &&
          (best < 0 || slot_handle[i] < slot_handle[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic voice_reply_t voice_table_step(voice_req_t q);
    voice_reply_t r;
    int ch;
    int f;
    r  = res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0, vca_pkg::PS_STOPPED, 1'b0, 8'h00);
    ch = -1;
    case (q.cmd)
      vca_pkg::CMD_PLAY: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (ch < 0 && (slot_handle[i] == 32'h0 || !q.busy_mask[i])) ch = i;
        end
        if (ch < 0) begin
          ch = oldest_slot(PICK_SAME, q.sound);
          if (ch < 0) ch = oldest_slot(PICK_LOOP, q.sound);
          if (ch < 0) ch = oldest_slot(PICK_ANY, q.sound);
          r.stolen = 1'b1;
        end
        if (ch < 0) ch = 0;
        last_issued = last_issued + 32'd1;
        if (last_issued == 32'h0) last_issued = 32'd1;
        slot_handle[ch]  = last_issued;
        slot_sound[ch]   = q.sound;
        slot_looping[ch] = q.looping;
        slot_paused[ch]  = 1'b0;
        r.handle  = last_issued;
        r.channel = ch[2:0];
        r.action  = q.looping ? vca_pkg::ACT_START_LOOP : vca_pkg::ACT_START_ONCE;
      end
      vca_pkg::CMD_STOP, vca_pkg::CMD_PAUSE, vca_pkg::CMD_RESUME: begin
        f = find_slot(q.handle);
        if (f < 0) begin
          r.not_found = 1'b1;
        end else begin
          r.channel = f[2:0];
          if (q.cmd == vca_pkg::CMD_STOP) begin
            clear_slot(f);
            r.action = vca_pkg::ACT_HALT;
          end else if (q.cmd == vca_pkg::CMD_PAUSE) begin
            if (!slot_paused[f]) begin
              slot_paused[f] = 1'b1;
              r.action = vca_pkg::ACT_PAUSE;
            end
          end else if (slot_paused[f]) begin
            slot_paused[f] = 1'b0;
            r.action = vca_pkg::ACT_RESUME;
          end
        end
      end
      vca_pkg::CMD_QUERY: begin
        f = find_slot(q.handle);
        if (f >= 0) r.pstate = slot_paused[f] ? vca_pkg::PS_PAUSED : vca_pkg::PS_PLAYING;
      end
      vca_pkg::CMD_STOP_ALL: begin
        for (int i = 0; i < NUM_CH; i++) clear_slot(i);
        r.action = vca_pkg::ACT_HALT_ALL;
      end
      vca_pkg::CMD_UPDATE: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (slot_handle[i] != 32'h0 && !q.busy_mask[i]) begin
            clear_slot(i);
            r.freed[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return slot_handle[$urandom_range(0, NUM_CH - 1)];
    if (r < 80) return last_issued - 32'($urandom_range(0, 20));
    return $urandom();
  endfunction

  function automatic logic [7:0] play_busy();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'hFF;
    if (r < 80) return ~(8'h01 << $urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic voice_req_t rand_req();
    voice_req_t q;
    int r;
    r = $urandom_range(0, 99);
    q = row(vca_pkg::CMD_PLAY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            $urandom(), 8'($urandom_range(0, 255)));
    if (r < 40) begin
      if ($urandom_range(0, 1) == 0) q.sound = 8'($urandom_range(0, 3));
      q.busy_mask = play_busy();
    end else if (r < 82) begin
      if (r < 52)      q.cmd = vca_pkg::CMD_STOP;
      else if (r < 62) q.cmd = vca_pkg::CMD_PAUSE;
      else if (r < 72) q.cmd = vca_pkg::CMD_RESUME;
      else             q.cmd = vca_pkg::CMD_QUERY;
      q.handle = pick_handle();
    end else if (r < 84) begin
      q.cmd = vca_pkg::CMD_STOP_ALL;
    end else if (r < 95) begin
      q.cmd = vca_pkg::CMD_UPDATE;
      if ($urandom_range(0, 99) < 70) q.busy_mask = play_busy();
    end else begin
      q.cmd = CMD_UNUSED;
    end
    return q;
  endfunction

  task automatic issue(voice_req_t q);
    voice_reply_t r;
    if (!quiet && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= q.cmd;
    in_sound_id  <= q.sound;
    in_loop_flag <= q.looping;
    in_handle_in <= q.handle;
    in_busy_mask <= q.busy_mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = voice_table_step(q);
    predicted_replies.push_back(q.typed ? q.want : r);
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      reply_count <= reply_count + 1;
      got = res(out_handle_out, out_channel_out, out_mixer_action, out_voice_stolen,
                out_play_state, out_not_found, out_freed_mask);
      if (predicted_replies.size() == 0) begin
        note_error($sformatf("tb_top: unexpected reply %0d: h=%h ch=%0d act=%0d",
                             reply_count, got.handle, got.channel, got.action));
      end else begin
        want_now = predicted_replies.pop_front();
        if (got.handle !== want_now.handle || got.channel !== want_now.channel ||
            got.action !== want_now.action || got.stolen !== want_now.stolen ||
            got.pstate !== want_now.pstate || got.not_found !== want_now.not_found ||
            got.freed !== want_now.freed)
          note_error($sformatf(
            "tb_top: reply %0d want h=%h ch=%0d act=%0d st=%b ps=%0d nf=%b fm=%h %s%h %s",
            reply_count, want_now.handle, want_now.channel, want_now.action,
            want_now.stolen, want_now.pstate, want_now.not_found, want_now.freed,
            "got h=", got.handle,
            $sformatf("ch=%0d act=%0d st=%b ps=%0d nf=%b fm=%h", got.channel, got.action,
                      got.stolen, got.pstate, got.not_found, got.freed)));
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) clear_slot(i);
    last_issued = 32'h0;

    plan.push_back(row_chk(vca_pkg::CMD_QUERY, 8'h00, 1'b0, 32'h0, 8'h00,
                           res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));
    plan.push_back(row_chk(vca_pkg::CMD_STOP, 8'h00, 1'b0, 32'h0, 8'h00,
                           res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b1, 8'h00)));
    plan.push_back(row_chk(vca_pkg::CMD_PAUSE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF,
                           res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b1, 8'h00)));
    plan.push_back(row_chk(CMD_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF,
                           res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));
    plan.push_back(row_chk(vca_pkg::CMD_UPDATE, 8'h00, 1'b0, 32'h0, 8'h00,
                           res(32'h0, 3'd0, vca_pkg::ACT_NONE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));
    plan.push_back(row_chk(vca_pkg::CMD_PLAY, 8'h00, 1'b0, 32'h0, 8'hFF,
                           res(32'd1, 3'd0, vca_pkg::ACT_START_ONCE, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));
    plan.push_back(row_chk(vca_pkg::CMD_PLAY, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF,
                           res(32'd2, 3'd1, vca_pkg::ACT_START_LOOP, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd5, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd5, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd7, 1'b1, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd9, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd11, 1'b1, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd13, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd5, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd200, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd201, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd202, 1'b0, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd203, 1'b1, 32'h0, 8'hFF));
    plan.push_back(row(vca_pkg::CMD_PAUSE, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_PAUSE, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_QUERY, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_RESUME, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_RESUME, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_STOP, 8'h00, 1'b0, 32'd4, 8'h00));
    plan.push_back(row(vca_pkg::CMD_PLAY, 8'd5, 1'b0, 32'h0, 8'hFE));
    plan.push_back(row(vca_pkg::CMD_UPDATE, 8'h00, 1'b0, 32'h0, 8'h5A));
    plan.push_back(row_chk(vca_pkg::CMD_STOP_ALL, 8'h00, 1'b0, 32'h0, 8'h00,
                           res(32'h0, 3'd0, vca_pkg::ACT_HALT_ALL, 1'b0,
                               vca_pkg::PS_STOPPED, 1'b0, 8'h00)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) issue(plan[i]);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      quiet = (n >= 700 && n < 1000);
      issue(rand_req());
    end

    // drop start once the last word is taken
    start <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (NUM_CH + 12) @(posedge clk);

    if (err_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
